// ===== design/sbvd_pkg.sv =====
// Shared types and constants for the stop-bit varint decoder.
// No dependencies.
package sbvd_pkg;

	localparam int unsigned GROUP_BITS   = 7;
	localparam logic [3:0]  COUNT_MAX    = 4'd15;
	localparam logic [3:0]  POS_MAX_CONT = 4'd8;
	localparam logic [3:0]  NEG_MAX_CONT = 4'd9;
	localparam int unsigned VALUE_W      = 64;
	localparam int unsigned LEN_W        = 4;
	localparam int unsigned OUT_TDATA_W  = 72;

	typedef struct packed {
		logic                emit;
		logic [VALUE_W-1:0]  value;
		logic [LEN_W-1:0]    length;
		logic                error;
	} sbvd_result_t;

endpackage

// ===== design/sbvd_core.sv =====
// Decode step: accumulator and continuation count, plus the per-byte logic.
// Depends on sbvd_pkg.
module sbvd_core import sbvd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step_en,
	input  logic [7:0]   byte_in,
	output logic         is_cont,
	output sbvd_result_t result
);

	logic [VALUE_W-1:0] acc_q;
	logic [3:0]         count_q;
	logic [6:0]         pos;
	logic [VALUE_W-1:0] group_shifted;
	logic [VALUE_W-1:0] final_shifted;

	assign is_cont = byte_in[7];
	assign pos     = 7'({3'b000, count_q} * 7'(GROUP_BITS));

	// positions of 64 and up drop out entirely
	assign group_shifted = (pos < 7'd64) ?
		({57'd0, byte_in[6:0]} << pos[5:0]) : '0;
	assign final_shifted = (pos < 7'd64) ?
		({56'd0, byte_in} << pos[5:0]) : '0;

	always_comb begin
		result.emit   = !is_cont;
		result.value  = '0;
		result.error  = 1'b0;
		result.length = (count_q < COUNT_MAX) ? count_q + 4'd1 : COUNT_MAX;
		if (count_q == 4'd0) begin
			result.value = {56'd0, byte_in};
		end else if (byte_in != 8'd0) begin
			if (count_q > POS_MAX_CONT)
				result.error = 1'b1;
			else
				result.value = acc_q | final_shifted;
		end else begin
			// zero stop byte after continuations: negative
			if (count_q > NEG_MAX_CONT)
				result.error = 1'b1;
			else
				result.value = ~acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
		end else if (step_en) begin
			if (is_cont) begin
				acc_q <= acc_q | group_shifted;
				if (count_q < COUNT_MAX)
					count_q <= count_q + 4'd1;
			end else begin
				acc_q   <= '0;
				count_q <= '0;
			end
		end
	end

endmodule

// ===== design/stop_bit_varint_decoder.sv =====
// Top level of the stop-bit varint decoder: input register, decode step,
// result register. Depends on sbvd_pkg and sbvd_core.
//
// Usage:
//   Slave channel s_* carries one encoded byte per request. Bit 7 set marks
//   a continuation byte; bit 7 clear ends the value.
//   Master channel m_* carries one result per stop byte: the signed 64-bit
//   value and the byte count (saturating at 15) in m_tdata, and an error
//   flag in m_tuser (encoding too long for its sign; value is then zero).
//   Continuation bytes produce no result.
// Path: an accepted stop byte is decoded out of the input register into the
//   result register, and then shows on m_*.
// Throughput: one byte per cycle unless a stop byte stalls (see Stall); the
//   decode step is a single shift, OR and compare between the two registers.
// Reset: arst_n clears both valid flags, the accumulator and the count, so
//   the first byte after reset starts a fresh value.
// Stall: when m_tready is low with a result held, a stop byte waits in the
//   input register and s_tready drops; continuation bytes keep flowing
//   since they need no result slot.
module stop_bit_varint_decoder import sbvd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // [7:0] byte_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [63:0] value, [67:64] length, [71:68] zero
	output logic                   m_tuser   // [0] error
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [LEN_W-1:0]   length_q;
	logic         error_q;
	logic         is_cont;
	logic         advance;
	logic         out_free;
	sbvd_result_t result;

	assign out_free = !out_valid_q || m_tready;
	// a continuation byte never needs the result slot
	assign advance  = valid_s1 && (is_cont || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	sbvd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.byte_in (byte_s1),
		.is_cont (is_cont),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && result.emit) begin
			value_q  <= result.value;
			length_q <= result.length;
			error_q  <= result.error;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, length_q, value_q};
	assign m_tuser  = error_q;

endmodule

// ===== tb/sv/tb_stop_bit_varint_decoder.sv =====
// Testbench for stop_bit_varint_decoder: byte stream in, decoded values checked
// against a cycle-free predictor. Depends on sbvd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_stop_bit_varint_decoder;
	import sbvd_pkg::*;

	// One decoded value as the block should report it.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [LEN_W-1:0]   nbytes;
		logic               too_long;
	} decoded_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;   // [7:0] byte_in
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [63:0] value, [67:64] length, [71:68] zero
	logic                   m_tuser;   // [0] error

	// Predictor state: bits gathered so far and continuation bytes seen.
	logic [VALUE_W-1:0] acc_bits = '0;
	logic [3:0]         run_cnt  = '0;

	decoded_t pending_q[$];   // decoded values still owed by the block
	int       fail_count = 0;
	int       bytes_sent = 0;
	bit       tx_jitter  = 1'b1;   // sender inserts random gaps
	bit       rx_jitter  = 1'b1;   // receiver inserts random stalls
	int       hold_left  = 0;      // long receiver hold-off, counted down by the sink
	int       gap_left   = 0;

	stop_bit_varint_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Advance the predictor by one byte; returns 1 when the byte ends a value.
	function automatic logic decode_step(input logic [7:0] b, output decoded_t r);
		logic [3:0]  k;
		int unsigned pos;
		k   = run_cnt;
		pos = k * GROUP_BITS;
		r   = '0;
		if (b[7]) begin
			// continuation: groups at position 64 and up fall off the top
			if (pos < VALUE_W)
				acc_bits = acc_bits | ({57'd0, b[6:0]} << pos);
			if (k < COUNT_MAX)
				run_cnt = k + 4'd1;
			return 1'b0;
		end
		r.nbytes = (k < COUNT_MAX) ? k + 4'd1 : COUNT_MAX;
		if (k == 4'd0) begin
			r.value = {56'd0, b};          // lone byte is the value, zero included
		end else if (b != 8'd0) begin
			if (k > POS_MAX_CONT)
				r.too_long = 1'b1;
			else
				r.value = acc_bits | ({56'd0, b} << pos);
		end else begin
			// zero stop byte after continuations: negative
			if (k > NEG_MAX_CONT)
				r.too_long = 1'b1;
			else
				r.value = ~acc_bits;
		end
		acc_bits = '0;
		run_cnt  = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < 20)
			$display("mismatch %s: got %h, want %h (t=%0t)", what, got, want, $realtime);
		fail_count++;
	endtask

	// Offer one byte as a request; returns once it is accepted. Valid stays high
	// into the next call so back-to-back requests need no dip.
	task automatic send_byte(input logic [7:0] b);
		int       gap;
		decoded_t r;
		gap = tx_jitter ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		if (decode_step(b, r))
			pending_q.push_back(r);
		bytes_sent++;
	endtask

	// n_cont continuation bytes (fixed or random groups) followed by a stop byte.
	task automatic send_run(input int n_cont, input logic [6:0] fill, input bit rand_fill,
			input logic [7:0] stop);
		logic [6:0] grp;
		for (int i = 0; i < n_cont; i++) begin
			grp = rand_fill ? 7'($urandom_range(0, 127)) : fill;
			send_byte({1'b1, grp});
		end
		send_byte(stop);
	endtask

	// Result sink: random stalls per result, plus the long hold-off when asked.
	initial begin : result_sink
		decoded_t want;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (gap_left > 0) begin
				m_tready <= 1'b0;
				gap_left--;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[63:0], '0);
				end else begin
					want = pending_q.pop_front();
					if (m_tdata[63:0] !== want.value)
						report_mismatch("value", m_tdata[63:0], want.value);
					if (m_tdata[67:64] !== want.nbytes)
						report_mismatch("length", {60'd0, m_tdata[67:64]},
							{60'd0, want.nbytes});
					if (m_tuser !== want.too_long)
						report_mismatch("error flag", {63'd0, m_tuser},
							{63'd0, want.too_long});
				end
				gap_left = rx_jitter ? $urandom_range(0, 5) : 0;
			end
		end
	end

	// Single-byte values (zero stays zero, top of the 7-bit range) and a two-byte -1.
	task automatic test_single_bytes();
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h7F);
		send_run(1, 7'h00, 1'b0, 8'h00);   // one continuation then zero stop: -1
	endtask

	// Widest legal encodings for each sign.
	task automatic test_range_extremes();
		send_run(8, 7'h7F, 1'b0, 8'h7F);   // largest positive
		send_run(9, 7'h7F, 1'b0, 8'h00);   // most negative
	endtask

	// Encodings too long for their sign, and a run past the count ceiling where
	// high groups are dropped and length saturates.
	task automatic test_overlong();
		send_run(9, 7'h55, 1'b0, 8'h01);
		send_run(10, 7'h2A, 1'b0, 8'h00);
		send_run(16, 7'h7F, 1'b0, 8'h05);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the result slot and input register fill and s_tready drops.
	task automatic test_stall_fill();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		hold_left = 120;
		for (int i = 0; i < 30; i++) begin
			if ($urandom_range(0, 2) == 0)
				send_run($urandom_range(1, 4), 7'h00, 1'b1, 8'($urandom_range(0, 127)));
			else
				send_byte(8'($urandom_range(0, 127)));
		end
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
	endtask

	// Mostly well-formed runs with random groups, some overlong runs and raw noise.
	task automatic test_random_stream();
		int         pick;
		int         n_cont;
		logic [7:0] stop;
		while (bytes_sent < 850) begin
			// switch idling on and off now and then so some stretches run flat out
			if ($urandom_range(0, 15) == 0)
				tx_jitter = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 15) == 0)
				rx_jitter = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 20) begin
				send_byte(8'($urandom_range(0, 127)));
			end else begin
				n_cont = (pick < 85) ? $urandom_range(1, 9) : $urandom_range(9, 18);
				stop   = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 127));
				send_run(n_cont, 7'h00, 1'b1, stop);
			end
		end
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_bytes();
		test_range_extremes();
		test_overlong();
		test_stall_fill();
		test_random_stream();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		// the result path has two registers; the extra edges here catch stray results
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#200000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
